// ===== rtl/core/tcec_pkg.sv =====
// Shared types, constants and lookup tables for the tetra cell edge classifier.
// No dependencies; every other file in rtl/core imports this package.
package tcec_pkg;

	// Point, edge and tetrahedron counts of one cell
	localparam int POINT_COUNT = 15;
	localparam int EDGE_COUNT  = 54;
	localparam int TET_COUNT   = 28;
	localparam int COUNT_W     = 6;

	// Popcount grouping for the registered adder tree in the back end
	localparam int VGRP_COUNT = 7;
	localparam int VGRP_BITS  = 8;
	localparam int TGRP_COUNT = 4;
	localparam int TGRP_TETS  = 7;
	localparam int GRP_W      = 4;

	// Queue between front and back
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = 2;
	localparam int QCOUNT_W    = 3;

	typedef logic [3:0] point_idx_t;
	typedef logic [EDGE_COUNT-1:0] edge_vec_t;

	// Classified cell: high bit per point and the far-side flags {z, y, x}
	typedef struct packed {
		logic [POINT_COUNT-1:0] high;
		logic [2:0]             last_in;
	} cls_item_t;

	// Ownership masks
	localparam edge_vec_t MAIN_EDGES = edge_vec_t'({33{1'b1}});
	localparam edge_vec_t FAR_X = (edge_vec_t'(1) << 33) | (edge_vec_t'(1) << 35) |
		(edge_vec_t'(1) << 42) | (edge_vec_t'(1) << 43) | (edge_vec_t'(1) << 44) |
		(edge_vec_t'(1) << 45);
	localparam edge_vec_t FAR_Y = (edge_vec_t'(1) << 34) | (edge_vec_t'(1) << 37) |
		(edge_vec_t'(1) << 46) | (edge_vec_t'(1) << 47) | (edge_vec_t'(1) << 48) |
		(edge_vec_t'(1) << 49);
	localparam edge_vec_t FAR_Z = (edge_vec_t'(1) << 38) | (edge_vec_t'(1) << 41) |
		(edge_vec_t'(1) << 50) | (edge_vec_t'(1) << 51) | (edge_vec_t'(1) << 52) |
		(edge_vec_t'(1) << 53);
	localparam edge_vec_t EDGE_XY = edge_vec_t'(1) << 36;
	localparam edge_vec_t EDGE_XZ = edge_vec_t'(1) << 39;
	localparam edge_vec_t EDGE_YZ = edge_vec_t'(1) << 40;

	// Edge end points, in mask bit order
	localparam point_idx_t EDGE_A [EDGE_COUNT] = '{
		4'd0, 4'd0, 4'd0,
		4'd10, 4'd10, 4'd10, 4'd10,
		4'd9, 4'd9, 4'd9, 4'd9,
		4'd8, 4'd8, 4'd8, 4'd8,
		4'd10, 4'd10, 4'd10, 4'd10,
		4'd14, 4'd13, 4'd8, 4'd9,
		4'd12, 4'd12, 4'd12, 4'd12,
		4'd11, 4'd11, 4'd11, 4'd11, 4'd11, 4'd11,
		4'd1, 4'd3, 4'd1, 4'd3, 4'd2, 4'd4, 4'd5, 4'd7, 4'd6,
		4'd12, 4'd12, 4'd12, 4'd12,
		4'd13, 4'd13, 4'd13, 4'd13,
		4'd14, 4'd14, 4'd14, 4'd14
	};
	localparam point_idx_t EDGE_B [EDGE_COUNT] = '{
		4'd1, 4'd2, 4'd4,
		4'd0, 4'd4, 4'd6, 4'd2,
		4'd0, 4'd4, 4'd5, 4'd1,
		4'd0, 4'd1, 4'd3, 4'd2,
		4'd8, 4'd9, 4'd14, 4'd13,
		4'd13, 4'd8, 4'd9, 4'd14,
		4'd8, 4'd9, 4'd14, 4'd13,
		4'd8, 4'd9, 4'd10, 4'd14, 4'd13, 4'd12,
		4'd3, 4'd2, 4'd5, 4'd7, 4'd6, 4'd5, 4'd7, 4'd6, 4'd4,
		4'd1, 4'd5, 4'd7, 4'd3,
		4'd2, 4'd6, 4'd7, 4'd3,
		4'd4, 4'd5, 4'd7, 4'd6
	};

	// Corner points of each tetrahedron
	localparam point_idx_t TET_P0 [TET_COUNT] = '{
		4'd4, 4'd6, 4'd2, 4'd0, 4'd5, 4'd7, 4'd3, 4'd1,
		4'd3, 4'd1, 4'd5, 4'd7, 4'd6, 4'd4, 4'd5, 4'd7,
		4'd2, 4'd0, 4'd1, 4'd3, 4'd11, 4'd11, 4'd11, 4'd11,
		4'd11, 4'd11, 4'd11, 4'd11
	};
	localparam point_idx_t TET_P1 [TET_COUNT] = '{
		4'd0, 4'd4, 4'd6, 4'd2, 4'd1, 4'd5, 4'd7, 4'd3,
		4'd2, 4'd0, 4'd4, 4'd6, 4'd10, 4'd14, 4'd9, 4'd12,
		4'd10, 4'd8, 4'd9, 4'd12, 4'd10, 4'd14, 4'd9, 4'd12,
		4'd10, 4'd8, 4'd9, 4'd12
	};
	localparam point_idx_t TET_P2 [TET_COUNT] = '{
		4'd10, 4'd10, 4'd10, 4'd10, 4'd12, 4'd12, 4'd12, 4'd12,
		4'd13, 4'd8, 4'd9, 4'd14, 4'd14, 4'd10, 4'd12, 4'd14,
		4'd8, 4'd10, 4'd12, 4'd8, 4'd14, 4'd10, 4'd12, 4'd14,
		4'd8, 4'd10, 4'd12, 4'd8
	};
	localparam point_idx_t TET_P3 [TET_COUNT] = '{
		4'd9, 4'd14, 4'd13, 4'd8, 4'd9, 4'd14, 4'd13, 4'd8,
		4'd8, 4'd9, 4'd14, 4'd13, 4'd13, 4'd9, 4'd14, 4'd13,
		4'd13, 4'd9, 4'd8, 4'd13, 4'd13, 4'd9, 4'd14, 4'd13,
		4'd13, 4'd9, 4'd8, 4'd13
	};

	// Edges this cell owns for the given far-side flags {z, y, x}
	function automatic edge_vec_t own_mask(input logic [2:0] last_in);
		edge_vec_t m;
		m = MAIN_EDGES;
		if (last_in[0]) m = m | FAR_X;
		if (last_in[1]) m = m | FAR_Y;
		if (last_in[2]) m = m | FAR_Z;
		if (last_in[0] && last_in[1]) m = m | EDGE_XY;
		if (last_in[0] && last_in[2]) m = m | EDGE_XZ;
		if (last_in[1] && last_in[2]) m = m | EDGE_YZ;
		return m;
	endfunction

	// Triangles from one tetrahedron given its four high bits
	function automatic logic [1:0] tet_triangles(input logic [3:0] h);
		logic [2:0] cnt;
		cnt = 3'(h[0]) + 3'(h[1]) + 3'(h[2]) + 3'(h[3]);
		if (cnt == 3'd1 || cnt == 3'd3) return 2'd1;
		if (cnt == 3'd2) return 2'd2;
		return 2'd0;
	endfunction

endpackage

// ===== rtl/core/tcec_if.sv =====
// Channel interfaces of the tetra cell edge classifier: cell input and result.
// Depends on tcec_pkg for the result field widths.
interface tcec_cell_if #(parameter int SAMPLE_BITS = 24);
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] corner_dsw;
	logic signed [SAMPLE_BITS-1:0] corner_dse;
	logic signed [SAMPLE_BITS-1:0] corner_dnw;
	logic signed [SAMPLE_BITS-1:0] corner_dne;
	logic signed [SAMPLE_BITS-1:0] corner_usw;
	logic signed [SAMPLE_BITS-1:0] corner_use;
	logic signed [SAMPLE_BITS-1:0] corner_unw;
	logic signed [SAMPLE_BITS-1:0] corner_une;
	logic                          last_in_x;
	logic                          last_in_y;
	logic                          last_in_z;

	modport source (
		output valid, corner_dsw, corner_dse, corner_dnw, corner_dne,
		output corner_usw, corner_use, corner_unw, corner_une,
		output last_in_x, last_in_y, last_in_z,
		input  ready
	);
	modport sink (
		input  valid, corner_dsw, corner_dse, corner_dnw, corner_dne,
		input  corner_usw, corner_use, corner_unw, corner_une,
		input  last_in_x, last_in_y, last_in_z,
		output ready
	);
endinterface

interface tcec_result_if import tcec_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [EDGE_COUNT-1:0] edge_mask;
	logic [COUNT_W-1:0]    vertex_count;
	logic [COUNT_W-1:0]    triangle_count;

	modport source (
		output valid, edge_mask, vertex_count, triangle_count,
		input  ready
	);
	modport sink (
		input  valid, edge_mask, vertex_count, triangle_count,
		output ready
	);
endinterface

// ===== rtl/core/tetra_cell_edge_classifier.sv =====
// Pipeline: three front stages, a four-entry queue and three back stages, the last of which
//   is the output register.
// Throughput: one cell per cycle while nothing stalls; front and back are fully pipelined and a
//   four-entry queue lets each side stall on its own.
// Reset: arst_n clears all valids, queue pointers and iso_level (to zero);
//   no clearing pass, the block is ready for cells as soon as reset is released.
module tetra_cell_edge_classifier import tcec_pkg::*; #(
	parameter int SAMPLE_BITS = 24
) (
	input  logic                   clk,
	input  logic                   arst_n,
	tcec_cell_if.sink              cube,
	tcec_result_if.source          result,
	input  logic                   cfg_we,
	input  logic [SAMPLE_BITS-1:0] cfg_wdata
);

	logic signed [SAMPLE_BITS-1:0] iso_q;
	logic      fq_valid, fq_ready;
	cls_item_t fq_item;
	logic      qb_valid, qb_ready;
	cls_item_t qb_item;

	// Hold the iso level register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			iso_q <= '0;
		end else if (cfg_we) begin
			iso_q <= cfg_wdata;
		end
	end

	tcec_front #(.SAMPLE_BITS(SAMPLE_BITS)) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.iso_level  (iso_q),
		.cube       (cube),
		.item_valid (fq_valid),
		.item_ready (fq_ready),
		.item       (fq_item)
	);

	tcec_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (fq_valid),
		.push_ready (fq_ready),
		.push_item  (fq_item),
		.pop_valid  (qb_valid),
		.pop_ready  (qb_ready),
		.pop_item   (qb_item)
	);

	tcec_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (qb_valid),
		.item_ready (qb_ready),
		.item       (qb_item),
		.result     (result)
	);

endmodule

// ===== rtl/core/tcec_front.sv =====
// Front end: accepts cells, forms face and body sums and classifies all 15 points.
// Depends on tcec_pkg and tcec_cell_if.
module tcec_front import tcec_pkg::*; #(
	parameter int SAMPLE_BITS = 24
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic signed [SAMPLE_BITS-1:0] iso_level,
	tcec_cell_if.sink                     cube,
	output logic                          item_valid,
	input  logic                          item_ready,
	output cls_item_t                     item
);

	localparam int PW = SAMPLE_BITS + 1;
	localparam int FW = SAMPLE_BITS + 2;
	localparam int BW = SAMPLE_BITS + 3;

	logic                 adv;
	logic                 valid_s1, valid_s2, valid_s3;
	logic signed [PW-1:0] pair_a_s1, pair_b_s1, pair_c_s1, pair_d_s1;
	logic signed [PW-1:0] pair_e_s1, pair_f_s1, pair_g_s1, pair_h_s1;
	logic [7:0]           corner_hi_s1, corner_hi_s2;
	logic [2:0]           last_s1, last_s2;
	logic signed [FW-1:0] face_d_s2, face_s_s2, face_w_s2;
	logic signed [FW-1:0] face_e_s2, face_n_s2, face_u_s2;
	logic signed [FW-1:0] iso4;
	logic signed [BW-1:0] iso8;
	logic signed [BW-1:0] body;
	cls_item_t            item_s3;
	logic [POINT_COUNT-1:0] high_c;

	// Advance all stages together unless the last one is held
	assign adv        = !valid_s3 || item_ready;
	assign cube.ready = adv;

	// Stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= cube.valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	// Stage 1: pairwise corner sums and corner classes
	always_ff @(posedge clk) begin
		if (adv) begin
			pair_a_s1 <= {cube.corner_dsw[SAMPLE_BITS-1], cube.corner_dsw} +
				{cube.corner_dse[SAMPLE_BITS-1], cube.corner_dse};
			pair_b_s1 <= {cube.corner_dnw[SAMPLE_BITS-1], cube.corner_dnw} +
				{cube.corner_dne[SAMPLE_BITS-1], cube.corner_dne};
			pair_c_s1 <= {cube.corner_usw[SAMPLE_BITS-1], cube.corner_usw} +
				{cube.corner_use[SAMPLE_BITS-1], cube.corner_use};
			pair_d_s1 <= {cube.corner_unw[SAMPLE_BITS-1], cube.corner_unw} +
				{cube.corner_une[SAMPLE_BITS-1], cube.corner_une};
			pair_e_s1 <= {cube.corner_dsw[SAMPLE_BITS-1], cube.corner_dsw} +
				{cube.corner_usw[SAMPLE_BITS-1], cube.corner_usw};
			pair_f_s1 <= {cube.corner_dse[SAMPLE_BITS-1], cube.corner_dse} +
				{cube.corner_use[SAMPLE_BITS-1], cube.corner_use};
			pair_g_s1 <= {cube.corner_dnw[SAMPLE_BITS-1], cube.corner_dnw} +
				{cube.corner_unw[SAMPLE_BITS-1], cube.corner_unw};
			pair_h_s1 <= {cube.corner_dne[SAMPLE_BITS-1], cube.corner_dne} +
				{cube.corner_une[SAMPLE_BITS-1], cube.corner_une};
			corner_hi_s1 <= {
				cube.corner_une > iso_level, cube.corner_unw > iso_level,
				cube.corner_use > iso_level, cube.corner_usw > iso_level,
				cube.corner_dne > iso_level, cube.corner_dnw > iso_level,
				cube.corner_dse > iso_level, cube.corner_dsw > iso_level
			};
			last_s1 <= {cube.last_in_z, cube.last_in_y, cube.last_in_x};
		end
	end

	// Stage 2: face sums
	always_ff @(posedge clk) begin
		if (adv) begin
			face_d_s2    <= {pair_a_s1[PW-1], pair_a_s1} + {pair_b_s1[PW-1], pair_b_s1};
			face_s_s2    <= {pair_a_s1[PW-1], pair_a_s1} + {pair_c_s1[PW-1], pair_c_s1};
			face_w_s2    <= {pair_e_s1[PW-1], pair_e_s1} + {pair_g_s1[PW-1], pair_g_s1};
			face_e_s2    <= {pair_f_s1[PW-1], pair_f_s1} + {pair_h_s1[PW-1], pair_h_s1};
			face_n_s2    <= {pair_b_s1[PW-1], pair_b_s1} + {pair_d_s1[PW-1], pair_d_s1};
			face_u_s2    <= {pair_c_s1[PW-1], pair_c_s1} + {pair_d_s1[PW-1], pair_d_s1};
			corner_hi_s2 <= corner_hi_s1;
			last_s2      <= last_s1;
		end
	end

	// Scaled thresholds and body sum; compare exactly, no rounding
	assign iso4 = {iso_level, 2'b00};
	assign iso8 = {iso_level, 3'b000};
	assign body = {face_d_s2[FW-1], face_d_s2} + {face_u_s2[FW-1], face_u_s2};

	always_comb begin
		high_c = {
			face_u_s2 > iso4,
			face_n_s2 > iso4,
			face_e_s2 > iso4,
			body > iso8,
			face_w_s2 > iso4,
			face_s_s2 > iso4,
			face_d_s2 > iso4,
			corner_hi_s2
		};
	end

	// Stage 3: classified item
	always_ff @(posedge clk) begin
		if (adv) begin
			item_s3.high    <= high_c;
			item_s3.last_in <= last_s2;
		end
	end

	assign item_valid = valid_s3;
	assign item       = item_s3;

endmodule

// ===== rtl/core/tcec_queue.sv =====
// Short queue of classified cells between the front and back ends.
// Depends on tcec_pkg for the item type and depth.
module tcec_queue import tcec_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push_valid,
	output logic      push_ready,
	input  cls_item_t push_item,
	output logic      pop_valid,
	input  logic      pop_ready,
	output cls_item_t pop_item
);

	cls_item_t          mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]  wr_ptr_q, rd_ptr_q;
	logic [QCOUNT_W-1:0] count_q;
	logic               push, pop;

	assign push_ready = count_q != QCOUNT_W'(QUEUE_DEPTH);
	assign pop_valid  = count_q != '0;
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;
	assign pop_item   = mem_q[rd_ptr_q];

	// Store the incoming transaction
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			if (pop) rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			if (push && !pop) count_q <= count_q + QCOUNT_W'(1);
			else if (pop && !push) count_q <= count_q - QCOUNT_W'(1);
		end
	end

`ifndef NO_ASSERTIONS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= QCOUNT_W'(QUEUE_DEPTH))
		else $error("queue occupancy above depth");
	a_push_grows: assert property (@(posedge clk) disable iff (!arst_n)
		push && !pop |=> count_q == $past(count_q) + QCOUNT_W'(1))
		else $error("queue push without pop did not grow occupancy");
	a_pop_shrinks: assert property (@(posedge clk) disable iff (!arst_n)
		pop && !push |=> count_q == $past(count_q) - QCOUNT_W'(1))
		else $error("queue pop without push did not shrink occupancy");
	a_ptr_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == '0 || count_q == QCOUNT_W'(QUEUE_DEPTH)) |-> wr_ptr_q == rd_ptr_q)
		else $error("queue pointers disagree with occupancy");
`endif

endmodule

// ===== rtl/core/tcec_back.sv =====
// Back end: edge mask, owned vertex count and triangle count from classified cells.
// Depends on tcec_pkg tables and tcec_result_if.
module tcec_back import tcec_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	output logic        item_ready,
	input  cls_item_t   item,
	tcec_result_if.source result
);

	localparam int PAD_W = VGRP_COUNT * VGRP_BITS;

	logic                adv;
	logic                valid_s1, valid_s2, valid_s3;
	edge_vec_t           mask_c;
	edge_vec_t           mask_s1, mask_s2, mask_s3;
	edge_vec_t           owned_s1;
	logic [1:0]          tri_c [TET_COUNT];
	logic [1:0]          tri_s1 [TET_COUNT];
	logic [PAD_W-1:0]    owned_pad;
	logic [GRP_W-1:0]    vgrp_c [VGRP_COUNT];
	logic [GRP_W-1:0]    tgrp_c [TGRP_COUNT];
	logic [GRP_W-1:0]    vgrp_s2 [VGRP_COUNT];
	logic [GRP_W-1:0]    tgrp_s2 [TGRP_COUNT];
	logic [COUNT_W-1:0]  vcount_c, tcount_c;
	logic [COUNT_W-1:0]  vcount_s3, tcount_s3;

	// Advance all stages together unless the result is held
	assign adv        = !valid_s3 || result.ready;
	assign item_ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= item_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	// Crossed edges and per-tetrahedron triangles
	always_comb begin
		for (int e = 0; e < EDGE_COUNT; e++) begin
			mask_c[e] = item.high[EDGE_A[e]] ^ item.high[EDGE_B[e]];
		end
		for (int t = 0; t < TET_COUNT; t++) begin
			tri_c[t] = tet_triangles({item.high[TET_P3[t]], item.high[TET_P2[t]],
				item.high[TET_P1[t]], item.high[TET_P0[t]]});
		end
	end

	// Stage 1
	always_ff @(posedge clk) begin
		if (adv) begin
			mask_s1  <= mask_c;
			owned_s1 <= mask_c & own_mask(item.last_in);
			for (int t = 0; t < TET_COUNT; t++) begin
				tri_s1[t] <= tri_c[t];
			end
		end
	end

	// Partial popcounts and triangle sums
	assign owned_pad = PAD_W'(owned_s1);

	always_comb begin
		for (int g = 0; g < VGRP_COUNT; g++) begin
			vgrp_c[g] = '0;
			for (int b = 0; b < VGRP_BITS; b++) begin
				vgrp_c[g] = vgrp_c[g] + GRP_W'(owned_pad[g*VGRP_BITS+b]);
			end
		end
		for (int g = 0; g < TGRP_COUNT; g++) begin
			tgrp_c[g] = '0;
			for (int k = 0; k < TGRP_TETS; k++) begin
				tgrp_c[g] = tgrp_c[g] + GRP_W'(tri_s1[g*TGRP_TETS+k]);
			end
		end
	end

	// Stage 2
	always_ff @(posedge clk) begin
		if (adv) begin
			mask_s2 <= mask_s1;
			for (int g = 0; g < VGRP_COUNT; g++) begin
				vgrp_s2[g] <= vgrp_c[g];
			end
			for (int g = 0; g < TGRP_COUNT; g++) begin
				tgrp_s2[g] <= tgrp_c[g];
			end
		end
	end

	// Final sums
	always_comb begin
		vcount_c = '0;
		tcount_c = '0;
		for (int g = 0; g < VGRP_COUNT; g++) begin
			vcount_c = vcount_c + COUNT_W'(vgrp_s2[g]);
		end
		for (int g = 0; g < TGRP_COUNT; g++) begin
			tcount_c = tcount_c + COUNT_W'(tgrp_s2[g]);
		end
	end

	// Stage 3: output register
	always_ff @(posedge clk) begin
		if (adv) begin
			mask_s3   <= mask_s2;
			vcount_s3 <= vcount_c;
			tcount_s3 <= tcount_c;
		end
	end

	assign result.valid          = valid_s3;
	assign result.edge_mask      = mask_s3;
	assign result.vertex_count   = vcount_s3;
	assign result.triangle_count = tcount_s3;

endmodule

// ===== sim/tb_tetra_cell_edge_classifier.sv =====
// Testbench for tetra_cell_edge_classifier: directed cells, then random cells under several
// iso levels and idle/stall mixes, each result checked against an in-bench classifier or a given expectation.
// Depends on tcec_pkg and the channel interfaces in rtl/core.
module tb_tetra_cell_edge_classifier;
	import tcec_pkg::*;

	localparam int SB            = 24;
	localparam int HALF_PERIOD   = 6;
	localparam int RESET_CYCLES  = 6;
	localparam int SETTLE_CYCLES = 12;
	localparam int HOLD_CYCLES   = 100;
	localparam int STALL_LIMIT   = 2000;
	localparam int REPORT_CAP    = 100;

	localparam logic [SB-1:0] S_ZERO = '0;
	localparam logic [SB-1:0] S_ONE  = SB'(1);
	localparam logic [SB-1:0] S_NEG1 = '1;
	localparam logic [SB-1:0] S_MAX  = {1'b0, {(SB-1){1'b1}}};
	localparam logic [SB-1:0] S_MIN  = {1'b1, {(SB-1){1'b0}}};
	localparam longint SAMPLE_HI = (longint'(1) <<< (SB-1)) - 1;
	localparam longint SAMPLE_LO = -(longint'(1) <<< (SB-1));

	// Point numbers: corners 0..7, then face and body centres
	localparam int P_DOWN  = 8;
	localparam int P_SOUTH = 9;
	localparam int P_WEST  = 10;
	localparam int P_BODY  = 11;
	localparam int P_EAST  = 12;
	localparam int P_NORTH = 13;
	localparam int P_UP    = 14;

	// Corner order: dsw, dse, dnw, dne, usw, use, unw, une; last_in is {z, y, x}
	typedef struct packed {
		logic [0:7][SB-1:0] corner;
		logic [2:0]         last_in;
	} cell_t;

	typedef struct packed {
		logic [EDGE_COUNT-1:0] edge_mask;
		logic [COUNT_W-1:0]    vertex_count;
		logic [COUNT_W-1:0]    triangle_count;
	} cell_result_t;

	typedef struct packed {
		cell_t        stim;
		logic         given;
		cell_result_t want;
	} dir_row_t;

	localparam cell_result_t NO_CROSSING = '{edge_mask: '0, vertex_count: '0, triangle_count: '0};

	localparam int EDGE_FROM [EDGE_COUNT] = '{
		0, 0, 0, 10, 10, 10, 10, 9, 9, 9, 9, 8, 8, 8, 8,
		10, 10, 10, 10, 14, 13, 8, 9, 12, 12, 12, 12,
		11, 11, 11, 11, 11, 11,
		1, 3, 1, 3, 2, 4, 5, 7, 6,
		12, 12, 12, 12, 13, 13, 13, 13, 14, 14, 14, 14
	};
	localparam int EDGE_TO [EDGE_COUNT] = '{
		1, 2, 4, 0, 4, 6, 2, 0, 4, 5, 1, 0, 1, 3, 2,
		8, 9, 14, 13, 13, 8, 9, 14, 8, 9, 14, 13,
		8, 9, 10, 14, 13, 12,
		3, 2, 5, 7, 6, 5, 7, 6, 4,
		1, 5, 7, 3, 2, 6, 7, 3, 4, 5, 7, 6
	};
	localparam int TET_CORNER [TET_COUNT][4] = '{
		'{4, 0, 10, 9}, '{6, 4, 10, 14}, '{2, 6, 10, 13}, '{0, 2, 10, 8},
		'{5, 1, 12, 9}, '{7, 5, 12, 14}, '{3, 7, 12, 13}, '{1, 3, 12, 8},
		'{3, 2, 13, 8}, '{1, 0, 8, 9}, '{5, 4, 9, 14}, '{7, 6, 14, 13},
		'{6, 10, 14, 13}, '{4, 14, 10, 9}, '{5, 9, 12, 14}, '{7, 12, 14, 13},
		'{2, 10, 8, 13}, '{0, 8, 10, 9}, '{1, 9, 12, 8}, '{3, 12, 8, 13},
		'{11, 10, 14, 13}, '{11, 14, 10, 9}, '{11, 9, 12, 14}, '{11, 12, 14, 13},
		'{11, 10, 8, 13}, '{11, 8, 10, 9}, '{11, 9, 12, 8}, '{11, 12, 8, 13}
	};

	// Directed cells at the reset iso level of zero
	localparam int N_DIRECTED = 20;
	localparam dir_row_t DIRECTED_ROWS [N_DIRECTED] = '{
		// uniform cells: every point on one side, so nothing crosses
		'{'{{8{S_ZERO}}, 3'b000}, 1'b1, NO_CROSSING},
		'{'{{8{S_ZERO}}, 3'b111}, 1'b1, NO_CROSSING},
		'{'{{8{S_MAX}}, 3'b101}, 1'b1, NO_CROSSING},
		'{'{{8{S_MIN}}, 3'b010}, 1'b1, NO_CROSSING},
		'{'{{8{S_NEG1}}, 3'b011}, 1'b1, NO_CROSSING},
		'{'{{8{S_ONE}}, 3'b110}, 1'b1, NO_CROSSING},
		// one high corner in turn, walking every far-side flag set
		'{'{{S_MAX, {7{S_ZERO}}}, 3'b000}, 1'b0, NO_CROSSING},
		'{'{{S_ZERO, S_MAX, {6{S_ZERO}}}, 3'b001}, 1'b0, NO_CROSSING},
		'{'{{{2{S_ZERO}}, S_MAX, {5{S_ZERO}}}, 3'b010}, 1'b0, NO_CROSSING},
		'{'{{{3{S_ZERO}}, S_MAX, {4{S_ZERO}}}, 3'b011}, 1'b0, NO_CROSSING},
		'{'{{{4{S_ZERO}}, S_MAX, {3{S_ZERO}}}, 3'b100}, 1'b0, NO_CROSSING},
		'{'{{{5{S_ZERO}}, S_MAX, {2{S_ZERO}}}, 3'b101}, 1'b0, NO_CROSSING},
		'{'{{{6{S_ZERO}}, S_MAX, S_ZERO}, 3'b110}, 1'b0, NO_CROSSING},
		'{'{{{7{S_ZERO}}, S_MAX}, 3'b111}, 1'b0, NO_CROSSING},
		// one deep low corner among barely high ones
		'{'{{S_MIN, {7{S_ONE}}}, 3'b111}, 1'b0, NO_CROSSING},
		// checkerboard of the extremes
		'{'{{S_MAX, S_MIN, S_MIN, S_MAX, S_MIN, S_MAX, S_MAX, S_MIN}, 3'b111}, 1'b0, NO_CROSSING},
		// mixed corners; the first has face and body sums exactly on the threshold
		'{'{{S_ONE, S_NEG1, S_NEG1, S_ONE, S_NEG1, S_ONE, S_ONE, S_NEG1}, 3'b111}, 1'b0,
			NO_CROSSING},
		'{'{{{7{S_MAX}}, S_MIN}, 3'b111}, 1'b0, NO_CROSSING},
		'{'{{{4{S_MAX}}, {4{S_MIN}}}, 3'b011}, 1'b0, NO_CROSSING},
		'{'{{S_MAX, {7{S_MIN}}}, 3'b101}, 1'b0, NO_CROSSING}
	};

	logic          clk = 1'b0;
	logic          arst_n;
	logic          cfg_we;
	logic [SB-1:0] cfg_wdata;

	tcec_cell_if #(.SAMPLE_BITS(SB)) cell_ch ();
	tcec_result_if                   res_ch ();

	tetra_cell_edge_classifier #(.SAMPLE_BITS(SB)) DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cube      (cell_ch),
		.result    (res_ch),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	logic [SB-1:0] iso_now = '0;
	cell_result_t  predicted_cells [$];
	int            mismatches    = 0;
	int            results_seen  = 0;
	int            send_idle_pct = 0;
	int            stall_pct     = 0;
	int            pressure_req  = 0;
	int            pressure_ack  = 0;
	int            quiet_cycles  = 0;

	always #HALF_PERIOD clk = ~clk;

	// Edges the cell owns for far-side flags {z, y, x}
	function automatic logic [EDGE_COUNT-1:0] owned_edges(input logic [2:0] far);
		logic [EDGE_COUNT-1:0] m;
		m = '0;
		m[32:0] = '1;
		if (far[0]) begin
			m[33] = 1'b1;
			m[35] = 1'b1;
			m[45:42] = '1;
		end
		if (far[1]) begin
			m[34] = 1'b1;
			m[37] = 1'b1;
			m[49:46] = '1;
		end
		if (far[2]) begin
			m[38] = 1'b1;
			m[41] = 1'b1;
			m[53:50] = '1;
		end
		if (far[0] && far[1]) m[36] = 1'b1;
		if (far[0] && far[2]) m[39] = 1'b1;
		if (far[1] && far[2]) m[40] = 1'b1;
		return m;
	endfunction

	// Class all 15 points exactly on the sums, then derive edges, owned count, triangles
	function automatic cell_result_t classify_cell(input cell_t c, input logic [SB-1:0] iso_bits);
		longint s [8];
		longint iso, f_down, f_south, f_west, f_east, f_north, f_up;
		bit hi [15];
		cell_result_t r;
		int n;
		iso = longint'($signed(iso_bits));
		for (int i = 0; i < 8; i++) begin
			s[i] = longint'($signed(c.corner[i]));
			hi[i] = s[i] > iso;
		end
		f_down  = s[0] + s[1] + s[2] + s[3];
		f_south = s[0] + s[4] + s[5] + s[1];
		f_west  = s[6] + s[2] + s[0] + s[4];
		f_east  = s[1] + s[3] + s[5] + s[7];
		f_north = s[2] + s[3] + s[6] + s[7];
		f_up    = s[4] + s[5] + s[6] + s[7];
		hi[P_DOWN]  = f_down > 4 * iso;
		hi[P_SOUTH] = f_south > 4 * iso;
		hi[P_WEST]  = f_west > 4 * iso;
		hi[P_BODY]  = (f_down + f_up) > 8 * iso;
		hi[P_EAST]  = f_east > 4 * iso;
		hi[P_NORTH] = f_north > 4 * iso;
		hi[P_UP]    = f_up > 4 * iso;
		r = NO_CROSSING;
		for (int e = 0; e < EDGE_COUNT; e++)
			r.edge_mask[e] = hi[EDGE_FROM[e]] != hi[EDGE_TO[e]];
		r.vertex_count = COUNT_W'($countones(r.edge_mask & owned_edges(c.last_in)));
		for (int t = 0; t < TET_COUNT; t++) begin
			n = 0;
			for (int k = 0; k < 4; k++)
				n += int'(hi[TET_CORNER[t][k]]);
			if (n == 1 || n == 3) r.triangle_count += 1;
			else if (n == 2) r.triangle_count += 2;
		end
		return r;
	endfunction

	// Mostly samples scattered around the iso level, some full range, some balanced on it
	function automatic cell_t random_cell(input logic [SB-1:0] iso_bits);
		cell_t c;
		longint base, v;
		int spread, pick;
		bit [7:0] flip;
		base = longint'($signed(iso_bits));
		pick = $urandom_range(99);
		flip = 8'b1001_0110;
		case ($urandom_range(4))
			0: spread = 2;
			1: spread = 8;
			2: spread = 300;
			3: spread = 100000;
			default: spread = 5000000;
		endcase
		v = longint'($urandom_range(spread));
		for (int i = 0; i < 8; i++) begin
			if (pick < 25) begin
				c.corner[i] = SB'($urandom());
			end else begin
				// balanced pattern offsets four corners up and four down by the same amount, before clamping
				if (pick < 35) v = flip[7-i] ? v : -v;
				else if ($urandom_range(7) == 0) v = 0;
				else v = longint'($urandom_range(2 * spread)) - spread;
				v = base + v;
				if (v > SAMPLE_HI) v = SAMPLE_HI;
				if (v < SAMPLE_LO) v = SAMPLE_LO;
				c.corner[i] = SB'(v);
				if (pick < 35) v = v - base;
			end
		end
		c.last_in = 3'($urandom_range(7));
		return c;
	endfunction

	task automatic report_mismatch(input string what, input logic [63:0] want,
			input logic [63:0] got);
		if (mismatches < REPORT_CAP)
			$display("result %0d %s: expected %h, got %h", results_seen, what, want, got);
		mismatches++;
	endtask

	// Offer one cell and hold it until the block takes it
	task automatic offer_cell(input cell_t c, input logic given, input cell_result_t want);
		cell_result_t exp_res;
		exp_res = given ? want : classify_cell(c, iso_now);
		while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
			cell_ch.valid <= 1'b0;
			@(posedge clk);
		end
		cell_ch.corner_dsw <= c.corner[0];
		cell_ch.corner_dse <= c.corner[1];
		cell_ch.corner_dnw <= c.corner[2];
		cell_ch.corner_dne <= c.corner[3];
		cell_ch.corner_usw <= c.corner[4];
		cell_ch.corner_use <= c.corner[5];
		cell_ch.corner_unw <= c.corner[6];
		cell_ch.corner_une <= c.corner[7];
		cell_ch.last_in_x  <= c.last_in[0];
		cell_ch.last_in_y  <= c.last_in[1];
		cell_ch.last_in_z  <= c.last_in[2];
		cell_ch.valid      <= 1'b1;
		do @(posedge clk); while (!cell_ch.ready);
		predicted_cells.push_back(exp_res);
	endtask

	// Wait until every result is back and the pipeline has drained
	task automatic settle();
		while (predicted_cells.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_iso(input logic [SB-1:0] level);
		cfg_we    <= 1'b1;
		cfg_wdata <= level;
		@(posedge clk);
		cfg_we    <= 1'b0;
		iso_now = level;
	endtask

	// One setting of the iso level with its own idle/stall mix
	task automatic stream_cells(input logic [SB-1:0] level, input int send_pct, input int stall,
			input int count, input bit pressure);
		settle();
		write_iso(level);
		send_idle_pct = send_pct;
		stall_pct     = stall;
		if (pressure) pressure_req++;
		repeat (count) offer_cell(random_cell(level), 1'b0, NO_CROSSING);
		cell_ch.valid <= 1'b0;
	endtask

	// Drive result ready: random stalls, plus a long hold-off on request
	initial begin
		int hold_left;
		hold_left = 0;
		res_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (pressure_req != pressure_ack) begin
				pressure_ack = pressure_req;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				res_ch.ready <= 1'b0;
			end else begin
				res_ch.ready <= (stall_pct == 0) || ($urandom_range(99) >= stall_pct);
			end
		end
	end

	// Check each result transaction against the oldest prediction
	always @(posedge clk) begin
		cell_result_t want;
		if (arst_n && res_ch.valid && res_ch.ready) begin
			if (predicted_cells.size() == 0) begin
				report_mismatch("unexpected result, edge_mask", '0, 64'(res_ch.edge_mask));
			end else begin
				want = predicted_cells.pop_front();
				if (res_ch.edge_mask !== want.edge_mask)
					report_mismatch("edge_mask", 64'(want.edge_mask), 64'(res_ch.edge_mask));
				if (res_ch.vertex_count !== want.vertex_count)
					report_mismatch("vertex_count", 64'(want.vertex_count),
						64'(res_ch.vertex_count));
				if (res_ch.triangle_count !== want.triangle_count)
					report_mismatch("triangle_count", 64'(want.triangle_count),
						64'(res_ch.triangle_count));
			end
			results_seen++;
		end
	end

	// End the run when no transaction moves for too long
	always @(posedge clk) begin
		if ((cell_ch.valid && cell_ch.ready) || (res_ch.valid && res_ch.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
			$display("== FAIL ==");
			$finish;
		end
	end

	initial begin
		arst_n             = 1'b0;
		cfg_we             = 1'b0;
		cfg_wdata          = '0;
		cell_ch.valid      = 1'b0;
		cell_ch.corner_dsw = '0;
		cell_ch.corner_dse = '0;
		cell_ch.corner_dnw = '0;
		cell_ch.corner_dne = '0;
		cell_ch.corner_usw = '0;
		cell_ch.corner_use = '0;
		cell_ch.corner_unw = '0;
		cell_ch.corner_une = '0;
		cell_ch.last_in_x  = 1'b0;
		cell_ch.last_in_y  = 1'b0;
		cell_ch.last_in_z  = 1'b0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed cells run on the reset iso level
		foreach (DIRECTED_ROWS[i])
			offer_cell(DIRECTED_ROWS[i].stim, DIRECTED_ROWS[i].given, DIRECTED_ROWS[i].want);
		cell_ch.valid <= 1'b0;

		stream_cells(S_ZERO, 0, 0, 110, 1'b0);
		stream_cells(SB'($urandom()), 51, 0, 90, 1'b0);
		stream_cells(S_MAX, 0, 51, 30, 1'b0);
		stream_cells(S_MIN, 32, 32, 30, 1'b0);
		stream_cells(SB'($urandom()), 0, 0, 80, 1'b1);
		stream_cells(SB'(longint'($urandom_range(2000)) - 1000), 0, 51, 90, 1'b0);
		stream_cells(SB'($urandom()), 32, 32, 100, 1'b0);
		stream_cells(S_MIN + SB'($urandom_range(50)), 51, 0, 40, 1'b0);

		settle();
		if (mismatches == 0 && predicted_cells.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

// ===== tetra_cell_edge_classifier.f =====
rtl/core/tcec_pkg.sv
rtl/core/tcec_if.sv
rtl/core/tcec_front.sv
rtl/core/tcec_queue.sv
rtl/core/tcec_back.sv
rtl/core/tetra_cell_edge_classifier.sv
sim/tb_tetra_cell_edge_classifier.sv
